@@ rtl/sfb_pkg.sv @@
package sfb_pkg;

   // request kinds, carried on req_tuser
   localparam logic [1:0] ACT_BINARY  = 2'd0;
   localparam logic [1:0] ACT_TEXT    = 2'd1;
   localparam logic [1:0] ACT_PAYLOAD = 2'd2;

   localparam logic [7:0] SYNC_A    = 8'd254;
   localparam logic [7:0] SYNC_B    = 8'd1;
   localparam logic [7:0] SYNC_C    = 8'd255;
   localparam logic [7:0] TEXT_ID_A = 8'd241;
   localparam logic [7:0] TEXT_ID_B = 8'd1;
   localparam logic [7:0] BYTE_CR   = 8'd13;
   localparam logic [7:0] BYTE_LF   = 8'd10;
   localparam logic [7:0] BYTE_ZERO = 8'd0;

   // SYNC_A + SYNC_B + SYNC_C, mod 256
   localparam logic [7:0] SYNC_SUM = 8'd254;

   localparam int REQ_DATA_W = 40;
   localparam int REQ_USER_W = 2;

   // byte positions inside one job; payload jobs begin at POS_DATA
   localparam int          POS_W     = 4;
   localparam logic [3:0]  POS_SYNC_A = 4'd0;
   localparam logic [3:0]  POS_SYNC_B = 4'd1;
   localparam logic [3:0]  POS_SYNC_C = 4'd2;
   localparam logic [3:0]  POS_ID_A   = 4'd3;
   localparam logic [3:0]  POS_ID_B   = 4'd4;
   localparam logic [3:0]  POS_LEN_LO = 4'd5;
   localparam logic [3:0]  POS_DATA   = 4'd6;
   localparam logic [3:0]  POS_SUM    = 4'd7;
   localparam logic [3:0]  POS_CR     = 4'd8;
   localparam logic [3:0]  POS_LF     = 4'd9;

   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   typedef struct packed {
      logic        payload;   // 1: payload byte, 0: frame start
      logic        text;
      logic        last;      // tail follows this job
      logic [7:0]  msg_class;
      logic [7:0]  msg_index;
      logic [15:0] payload_len;
      logic [7:0]  data_byte;
      logic [7:0]  sum;       // checksum as of the end of this job
   } job_type;

endpackage

@@ rtl/sfb_front.sv @@
module sfb_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   // msg_class[7:0], msg_index[15:8], payload_len[31:16], data_byte[39:32]
   input  logic [sfb_pkg::REQ_DATA_W-1:0] req_tdata,
   // action[1:0]
   input  logic [sfb_pkg::REQ_USER_W-1:0] req_tuser,
   input  logic                         q_full,
   output logic                         push,
   output sfb_pkg::job_type             push_job
);

   logic        frame_open_ff, frame_open_in;
   logic        text_mode_ff, text_mode_in;
   logic [15:0] bytes_left_ff, bytes_left_in;
   logic [7:0]  running_sum_ff, running_sum_in;

   logic        accept;
   logic [7:0]  msg_class, msg_index, data_byte;
   logic [15:0] payload_len;
   logic [15:0] left_dec;
   logic [7:0]  hdr_sum, pay_sum;

   assign req_tready  = !q_full;
   assign accept      = req_tvalid && req_tready;
   assign msg_class   = req_tdata[7:0];
   assign msg_index   = req_tdata[15:8];
   assign payload_len = req_tdata[31:16];
   assign data_byte   = req_tdata[39:32];

   assign hdr_sum  = sfb_pkg::SYNC_SUM + msg_class + msg_index
                     + payload_len[7:0] + payload_len[15:8];
   assign pay_sum  = running_sum_ff + data_byte;
   assign left_dec = bytes_left_ff - 16'd1;

   always_comb begin
      frame_open_in  = frame_open_ff;
      text_mode_in   = text_mode_ff;
      bytes_left_in  = bytes_left_ff;
      running_sum_in = running_sum_ff;
      push           = 1'b0;
      push_job             = '0;
      push_job.msg_class   = msg_class;
      push_job.msg_index   = msg_index;
      push_job.payload_len = payload_len;
      push_job.data_byte   = data_byte;
      if (accept) begin
         case (req_tuser)
            sfb_pkg::ACT_BINARY, sfb_pkg::ACT_TEXT: begin
               if (!frame_open_ff) begin
                  push          = 1'b1;
                  push_job.text = (req_tuser == sfb_pkg::ACT_TEXT);
                  push_job.last = (payload_len == 16'd0);
                  push_job.sum  = hdr_sum;
                  if (payload_len != 16'd0) begin
                     frame_open_in  = 1'b1;
                     text_mode_in   = (req_tuser == sfb_pkg::ACT_TEXT);
                     bytes_left_in  = payload_len;
                     running_sum_in = (req_tuser == sfb_pkg::ACT_TEXT) ? 8'd0 : hdr_sum;
                  end
               end
            end
            sfb_pkg::ACT_PAYLOAD: begin
               if (frame_open_ff) begin
                  push             = 1'b1;
                  push_job.payload = 1'b1;
                  push_job.text    = text_mode_ff;
                  push_job.last    = (left_dec == 16'd0);
                  push_job.sum     = pay_sum;
                  if (left_dec == 16'd0) begin
                     frame_open_in  = 1'b0;
                     text_mode_in   = 1'b0;
                     bytes_left_in  = 16'd0;
                     running_sum_in = 8'd0;
                  end else begin
                     bytes_left_in  = left_dec;
                     running_sum_in = text_mode_ff ? running_sum_ff : pay_sum;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_open_ff  <= 1'b0;
         text_mode_ff   <= 1'b0;
         bytes_left_ff  <= 16'd0;
         running_sum_ff <= 8'd0;
      end else begin
         frame_open_ff  <= frame_open_in;
         text_mode_ff   <= text_mode_in;
         bytes_left_ff  <= bytes_left_in;
         running_sum_ff <= running_sum_in;
      end
   end

   // an open frame always has payload outstanding
   a_open_has_bytes: assert property (@(posedge clock) disable iff (reset)
      frame_open_ff |-> (bytes_left_ff != 16'd0))
      else $error("open frame with no bytes left");

endmodule

@@ rtl/sfb_queue.sv @@
module sfb_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  sfb_pkg::job_type push_job,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output sfb_pkg::job_type head_job
);

   sfb_pkg::job_type            slot_ff [sfb_pkg::QDEPTH];
   logic [sfb_pkg::QPTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [sfb_pkg::QCNT_W-1:0]  count_ff;

   assign full       = (count_ff == sfb_pkg::QCNT_W'(sfb_pkg::QDEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("job pushed into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && !head_valid))
      else $error("job popped from empty queue");

endmodule

@@ rtl/sfb_back.sv @@
module sfb_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             head_valid,
   input  sfb_pkg::job_type head_job,
   output logic             pop,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [7:0]       rsp_tdata,   // out_byte[7:0]
   output logic             rsp_tlast    // frame_end
);

   logic [sfb_pkg::POS_W-1:0] step_ff, step_in;
   logic [sfb_pkg::POS_W-1:0] pos;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [7:0]                rsp_data_ff;
   logic                      rsp_last_ff;
   logic                      load;
   logic                      job_done;
   logic                      frame_end;
   logic [7:0]                byte_out;

   assign pos = step_ff + (head_job.payload ? sfb_pkg::POS_DATA : sfb_pkg::POS_SYNC_A);

   always_comb begin
      case (pos)
         sfb_pkg::POS_SYNC_A: byte_out = sfb_pkg::SYNC_A;
         sfb_pkg::POS_SYNC_B: byte_out = sfb_pkg::SYNC_B;
         sfb_pkg::POS_SYNC_C: byte_out = sfb_pkg::SYNC_C;
         sfb_pkg::POS_ID_A:   byte_out = head_job.text ? sfb_pkg::TEXT_ID_A
                                                       : head_job.msg_class;
         sfb_pkg::POS_ID_B:   byte_out = head_job.text ? sfb_pkg::TEXT_ID_B
                                                       : head_job.msg_index;
         sfb_pkg::POS_LEN_LO: byte_out = head_job.payload_len[7:0];
         sfb_pkg::POS_DATA:   byte_out = head_job.payload ? head_job.data_byte
                                                          : head_job.payload_len[15:8];
         sfb_pkg::POS_SUM:    byte_out = head_job.text ? sfb_pkg::BYTE_ZERO : head_job.sum;
         sfb_pkg::POS_CR:     byte_out = sfb_pkg::BYTE_CR;
         sfb_pkg::POS_LF:     byte_out = sfb_pkg::BYTE_LF;
         default:             byte_out = sfb_pkg::BYTE_ZERO;
      endcase
   end

   // text frames end on the zero byte, binary frames on LF
   assign frame_end = ((pos == sfb_pkg::POS_SUM) && head_job.text) || (pos == sfb_pkg::POS_LF);
   assign job_done  = ((pos == sfb_pkg::POS_DATA) && !head_job.last) || frame_end;

   assign load = head_valid && (!rsp_valid_ff || rsp_tready);
   assign pop  = load && job_done;

   always_comb begin
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         step_in      = job_done ? '0 : step_ff + 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff <= byte_out;
         rsp_last_ff <= frame_end;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      head_valid |-> (pos <= sfb_pkg::POS_LF))
      else $error("byte position past end of frame");

   a_end_pops: assert property (@(posedge clock) disable iff (reset)
      (load && frame_end) |-> pop)
      else $error("frame end without job retire");

endmodule

@@ rtl/serial_frame_builder.sv @@
// Serial frame builder: turns start and payload requests into frame bytes, one byte per
// response. A binary start (tuser 0) produces 254,1,255, msg_class, msg_index and the length
// low byte first; a text start (tuser 1) uses ids 241,1. Payload requests (tuser 2) pass their
// byte through. After the last payload byte a binary frame adds the 8-bit additive checksum,
// CR and LF; a text frame adds one zero byte. tlast marks the last byte of each frame. Starts
// while a frame is open, payload with no open frame and tuser 3 are taken and dropped. The
// byte sequencer emits one byte per cycle while the output does not stall, and the first byte of
// a request is offered once it has passed the job queue and the output register. A payload
// request occupies the sequencer for its data byte alone, so payload streams at one per cycle
// when the output does not stall; the last payload of a frame also emits the tail. A start
// request emits seven header bytes (eight or ten with zero length, tail included), and the
// 4-entry job queue in front of it keeps requests flowing while it works or the output stalls.
module serial_frame_builder (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // msg_class[7:0], msg_index[15:8], payload_len[31:16], data_byte[39:32]
   input  logic [sfb_pkg::REQ_DATA_W-1:0] req_tdata,
   // action[1:0]
   input  logic [sfb_pkg::REQ_USER_W-1:0] req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // out_byte[7:0]
   output logic [7:0]   rsp_tdata,
   output logic         rsp_tlast
);

   logic             q_full;
   logic             push;
   sfb_pkg::job_type push_job;
   logic             pop;
   logic             head_valid;
   sfb_pkg::job_type head_job;

   sfb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .push       (push),
      .push_job   (push_job)
   );

   sfb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   sfb_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

@@ verif/serial_frame_builder_tb.sv @@
module serial_frame_builder_tb;

   // tuser code the block must take and drop
   localparam logic [1:0] ACT_UNUSED = 2'd3;
   localparam int MAX_REPORTS = 10;
   localparam int DRAIN_CYCLES = 30;

   typedef struct packed {
      logic [7:0] value;
      logic       last;
   } frame_byte_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;

   // predicted framer state
   logic        fr_open;
   logic        fr_text;
   logic [15:0] fr_left;
   logic [7:0]  fr_sum;

   frame_byte_type frame_bytes_due[$];

   bit tx_idle = 1'b1;
   bit rx_idle = 1'b1;
   int hold_cycles = 0;
   int err_count = 0;
   int frames_closed = 0;
   int bytes_seen = 0;
   int reqs_sent = 0;

   serial_frame_builder i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #4 clock = ~clock;

   function automatic logic [7:0] rand_byte();
      return 8'($urandom);
   endfunction

   function automatic logic [15:0] rand_word();
      return 16'($urandom);
   endfunction

   function automatic void push_frame_byte(input logic [7:0] value, input logic last);
      frame_byte_type fb;
      fb.value = value;
      fb.last  = last;
      frame_bytes_due.push_back(fb);
   endfunction

   function automatic void close_frame();
      if (fr_text) begin
         push_frame_byte(sfb_pkg::BYTE_ZERO, 1'b1);
      end else begin
         push_frame_byte(fr_sum, 1'b0);
         push_frame_byte(sfb_pkg::BYTE_CR, 1'b0);
         push_frame_byte(sfb_pkg::BYTE_LF, 1'b1);
      end
      fr_open = 1'b0;
      fr_text = 1'b0;
      fr_left = '0;
      fr_sum  = '0;
      frames_closed++;
   endfunction

   function automatic void predict_frame_bytes(input logic [1:0] act, input logic [7:0] cls,
                                               input logic [7:0] idx, input logic [15:0] len,
                                               input logic [7:0] data);
      logic [7:0] hdr [0:6];
      logic [7:0] sum;
      case (act)
         sfb_pkg::ACT_BINARY, sfb_pkg::ACT_TEXT: begin
            if (!fr_open) begin
               hdr[0] = sfb_pkg::SYNC_A;
               hdr[1] = sfb_pkg::SYNC_B;
               hdr[2] = sfb_pkg::SYNC_C;
               hdr[3] = (act == sfb_pkg::ACT_BINARY) ? cls : sfb_pkg::TEXT_ID_A;
               hdr[4] = (act == sfb_pkg::ACT_BINARY) ? idx : sfb_pkg::TEXT_ID_B;
               hdr[5] = len[7:0];
               hdr[6] = len[15:8];
               sum = '0;
               for (int i = 0; i < 7; i++) begin
                  push_frame_byte(hdr[i], 1'b0);
                  sum = sum + hdr[i];
               end
               fr_text = (act == sfb_pkg::ACT_TEXT);
               fr_sum  = fr_text ? 8'd0 : sum;
               fr_left = len;
               fr_open = 1'b1;
               if (len == 16'd0)
                  close_frame();
            end
         end
         sfb_pkg::ACT_PAYLOAD: begin
            if (fr_open) begin
               push_frame_byte(data, 1'b0);
               if (!fr_text)
                  fr_sum = fr_sum + data;
               fr_left = fr_left - 16'd1;
               if (fr_left == 16'd0)
                  close_frame();
            end
         end
         default: ;
      endcase
   endfunction

   function automatic void check_rsp(input logic [7:0] value, input logic last);
      frame_byte_type want;
      bytes_seen++;
      if (frame_bytes_due.size() == 0) begin
         err_count++;
         if (err_count <= MAX_REPORTS)
            $display("ERROR: unexpected byte %0d last=%0b with nothing pending", value, last);
      end else begin
         want = frame_bytes_due.pop_front();
         if (value !== want.value || last !== want.last) begin
            err_count++;
            if (err_count <= MAX_REPORTS)
               $display("ERROR: byte %0d: expected %0d last=%0b, got %0d last=%0b",
                        bytes_seen, want.value, want.last, value, last);
         end
      end
   endfunction

   // drive at the falling edge, take the request at the rising edge it is accepted
   task automatic send_req(input logic [1:0] act, input logic [7:0] cls, input logic [7:0] idx,
                           input logic [15:0] len, input logic [7:0] data);
      int gap;
      gap = tx_idle ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tuser  <= act;
      req_tdata  <= {data, len, idx, cls};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_frame_bytes(act, cls, idx, len, data);
      reqs_sent++;
      @(negedge clock);
   endtask

   task automatic wait_drain();
      req_tvalid <= 1'b0;
      while (frame_bytes_due.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // an ignored request: inside a frame a start or tuser 3, outside a payload or tuser 3
   task automatic send_noise(input bit in_frame);
      logic [1:0] act;
      case ($urandom_range(0, 2))
         0: act = ACT_UNUSED;
         1: act = in_frame ? sfb_pkg::ACT_BINARY : sfb_pkg::ACT_PAYLOAD;
         default: act = in_frame ? sfb_pkg::ACT_TEXT : sfb_pkg::ACT_PAYLOAD;
      endcase
      send_req(act, rand_byte(), rand_byte(), rand_word(), rand_byte());
   endtask

   task automatic test_directed();
      tx_idle = 1'b1;
      rx_idle = 1'b1;
      send_req(sfb_pkg::ACT_BINARY, 8'h00, 8'h00, 16'd0, 8'hFF);
      send_req(sfb_pkg::ACT_BINARY, 8'hFF, 8'hFF, 16'd0, 8'h00);
      send_req(sfb_pkg::ACT_TEXT, 8'hFF, 8'h00, 16'd0, 8'h55);
      send_req(sfb_pkg::ACT_PAYLOAD, 8'h00, 8'h00, 16'd0, 8'hAA);
      send_req(ACT_UNUSED, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF);
      send_req(sfb_pkg::ACT_BINARY, 8'h12, 8'h34, 16'd3, 8'h00);
      send_req(sfb_pkg::ACT_TEXT, 8'h00, 8'h00, 16'hFFFF, 8'h00);
      send_req(sfb_pkg::ACT_PAYLOAD, 8'hFF, 8'hFF, 16'hFFFF, 8'h00);
      send_req(ACT_UNUSED, 8'h00, 8'h00, 16'd0, 8'h00);
      send_req(sfb_pkg::ACT_PAYLOAD, 8'h00, 8'h00, 16'd0, 8'hFF);
      send_req(sfb_pkg::ACT_BINARY, 8'hFF, 8'hFF, 16'd0, 8'hFF);
      send_req(sfb_pkg::ACT_PAYLOAD, 8'h00, 8'h00, 16'd0, 8'h80);
      send_req(sfb_pkg::ACT_TEXT, 8'h00, 8'h00, 16'd2, 8'h00);
      send_req(sfb_pkg::ACT_PAYLOAD, 8'h00, 8'h00, 16'd0, 8'h41);
      send_req(sfb_pkg::ACT_PAYLOAD, 8'h00, 8'h00, 16'd0, 8'h00);
      // header sum wraps past 255 before the payload is added
      send_req(sfb_pkg::ACT_BINARY, 8'hF0, 8'hF0, 16'd1, 8'h00);
      send_req(sfb_pkg::ACT_PAYLOAD, 8'h00, 8'h00, 16'd0, 8'hFF);
      send_req(sfb_pkg::ACT_TEXT, 8'h00, 8'h00, 16'd1, 8'h00);
      send_req(sfb_pkg::ACT_PAYLOAD, 8'h00, 8'h00, 16'd0, 8'hFF);
      send_req(sfb_pkg::ACT_BINARY, 8'h01, 8'h02, 16'h0100, 8'h00);
      wait_drain();
   endtask

   task automatic test_backpressure();
      tx_idle = 1'b0;
      rx_idle = 1'b0;
      // sink holds off while requests keep coming, so the job queue fills
      hold_cycles = 150;
      for (int i = 0; i < 256; i++) begin
         if (i == 0)
            hold_cycles = 150;
         send_req(sfb_pkg::ACT_PAYLOAD, rand_byte(), rand_byte(), rand_word(), rand_byte());
      end
      wait_drain();
      hold_cycles = 120;
      send_req(sfb_pkg::ACT_TEXT, rand_byte(), rand_byte(), 16'd20, rand_byte());
      for (int i = 0; i < 20; i++)
         send_req(sfb_pkg::ACT_PAYLOAD, rand_byte(), rand_byte(), rand_word(), rand_byte());
      wait_drain();
   endtask

   task automatic test_random_frames();
      int counted;
      int n;
      logic [1:0] kind;
      counted = 0;
      while (counted < 100) begin
         tx_idle = ($urandom_range(0, 4) != 0);
         rx_idle = ($urandom_range(0, 4) != 0);
         if ($urandom_range(0, 5) == 0)
            send_noise(1'b0);
         kind = ($urandom_range(0, 1) != 0) ? sfb_pkg::ACT_TEXT : sfb_pkg::ACT_BINARY;
         case ($urandom_range(0, 9))
            0: n = 0;
            1: n = $urandom_range(13, 40);
            default: n = $urandom_range(1, 12);
         endcase
         send_req(kind, rand_byte(), rand_byte(), n[15:0], rand_byte());
         counted++;
         for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) == 0)
               send_noise(1'b1);
            send_req(sfb_pkg::ACT_PAYLOAD, rand_byte(), rand_byte(), rand_word(), rand_byte());
            counted++;
         end
      end
      wait_drain();
   endtask

   initial begin : rsp_sink
      int gap;
      while (reset) @(negedge clock);
      forever begin
         gap = rx_idle ? $urandom_range(0, 7) : 0;
         if (hold_cycles > 0) begin
            gap = hold_cycles;
            hold_cycles = 0;
         end
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         check_rsp(rsp_tdata, rsp_tlast);
         @(negedge clock);
      end
   end

   initial begin : run_limit
      #5000000;
      $display("Simulation FAILED");
      $finish;
   end

   initial begin : main
      fr_open = 1'b0;
      fr_text = 1'b0;
      fr_left = '0;
      fr_sum  = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      test_backpressure();
      test_random_frames();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Covered %0d requests and %0d frames, %0d frame bytes checked, %0d mismatches.",
               reqs_sent, frames_closed, bytes_seen, err_count);
      $display("Included empty, ignored and stray requests, sink hold-off and a 256-byte frame.");
      if (err_count == 0 && frame_bytes_due.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
